// ===== src/itp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_TOP
    } itp_state_t;

    typedef logic [7:0] char_t;
    typedef logic [1:0] err_t;
    typedef logic [1:0] prec_t;

    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_CARET  = 8'h5E;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_NUL    = 8'h00;

    localparam char_t CH_0       = 8'h30;
    localparam char_t CH_9       = 8'h39;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam err_t ERR_NONE      = 2'd0;
    localparam err_t ERR_OVERFLOW  = 2'd1;
    localparam err_t ERR_UNDERFLOW = 2'd2;

    function automatic prec_t prec(input char_t c);
        prec_t p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end
        else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end
        else if (c == CH_CARET) begin
            p = 2'd3;
        end
        return p;
    endfunction

    function automatic logic is_alnum(input char_t c);
        return (c >= CH_0 && c <= CH_9) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

endpackage

`default_nettype wire

// ===== src/itp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shunting-yard infix to postfix converter. Characters enter one transaction
// at a time on the input channel; postfix characters leave one transaction at
// a time on the output channel, the terminating zero character (or a single
// error transaction on stack overflow/underflow) marked with last. After an
// error, characters are dropped up to and including the next end item. The
// operator stack lives in a registered-read RAM of STACK_DEPTH entries, and
// every look at its top is a RAM read issued in S_LOOK and used in S_TOP.
// An item returns to S_LOOK after each stack entry it emits, and it waits
// while the output cannot take a transaction. Alphanumerics, dropped items
// and pushes onto an empty stack need no look at the top. The input is
// stalled while an item is in work.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic                 kind,
    input  wire itp_pkg::char_t       in_char,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      itp_pkg::char_t       out_char,
    output      logic                 last,
    output      itp_pkg::err_t        error
);

    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    itp_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          disc_reg, disc_next;
    logic          out_valid_reg, out_valid_next;

    logic  kind_reg;
    char_t char_reg;
    char_t out_char_reg;
    logic  last_reg;
    err_t  error_reg;

    logic          in_take;
    logic          out_free;
    logic          emit;
    char_t         e_char;
    logic          e_last;
    err_t          e_err;
    logic [CW-1:0] count_m1;
    logic          full;

    logic          ram_we;
    logic          ram_re;
    char_t         ram_rdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign error     = error_reg;
    assign count_m1  = count_reg - 1'b1;
    assign full      = (count_reg >= CW'(STACK_DEPTH));

    itp_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(char_reg),
        .re   (ram_re),
        .raddr(count_m1[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            char_reg <= in_char;
        end
        if (emit)
        begin
            out_char_reg <= e_char;
            last_reg     <= e_last;
            error_reg    <= e_err;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        disc_next  = disc_reg;
        emit       = 1'b0;
        e_char     = CH_NUL;
        e_last     = 1'b0;
        e_err      = ERR_NONE;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (disc_reg)
                    begin
                        if (kind == KIND_END)
                        begin
                            disc_next  = 1'b0;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK:
            begin
                if (kind_reg == KIND_END)
                begin
                    if (count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        state_next = S_TOP;
                    end
                    else if (out_free)
                    begin
                        emit       = 1'b1;
                        e_last     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (is_alnum(char_reg))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_char     = char_reg;
                        state_next = S_IDLE;
                    end
                end
                else if (count_reg != '0)
                begin
                    ram_re     = 1'b1;
                    state_next = S_TOP;
                end
                else if (char_reg == CH_RPAREN)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_last     = 1'b1;
                        e_err      = ERR_UNDERFLOW;
                        count_next = '0;
                        disc_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TOP:
            begin
                if (kind_reg == KIND_END)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_char     = ram_rdata;
                        count_next = count_m1;
                        state_next = S_LOOK;
                    end
                end
                else if (char_reg == CH_RPAREN)
                begin
                    if (ram_rdata == CH_LPAREN)
                    begin
                        count_next = count_m1;
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        emit       = 1'b1;
                        e_char     = ram_rdata;
                        count_next = count_m1;
                        state_next = S_LOOK;
                    end
                end
                else if (char_reg != CH_LPAREN && prec(char_reg) <= prec(ram_rdata))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_char     = ram_rdata;
                        count_next = count_m1;
                        state_next = S_LOOK;
                    end
                end
                else if (full)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_last     = 1'b1;
                        e_err      = ERR_OVERFLOW;
                        count_next = '0;
                        disc_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && out_stall);
    end

endmodule

`default_nettype wire

// ===== bench/tb_infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;

    import itp_pkg::*;

    localparam int DEPTH           = 32;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        char_t ch;
        logic  last;
        err_t  err;
    } postfix_t;

    class postfix_scoreboard;
        char_t    op_stack[DEPTH];
        int       depth;
        bit       dropping;
        postfix_t expected[$];
        int       errors;

        function new();
            depth    = 0;
            dropping = 1'b0;
            errors   = 0;
        endfunction

        function bit is_operand(char_t c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");
        endfunction

        function logic [1:0] rank(char_t c);
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                return 2'd1;
            end
            if (c == CH_STAR || c == CH_SLASH)
            begin
                return 2'd2;
            end
            if (c == CH_CARET)
            begin
                return 2'd3;
            end
            return 2'd0;
        endfunction

        function void push_expected(char_t ch, logic l, err_t e);
            postfix_t r;
            r.ch   = ch;
            r.last = l;
            r.err  = e;
            expected.push_back(r);
        endfunction

        function void pop_operator();
            push_expected(op_stack[depth - 1], 1'b0, ERR_NONE);
            depth--;
        endfunction

        function void abort(err_t e);
            depth    = 0;
            dropping = 1'b1;
            push_expected(CH_NUL, 1'b1, e);
        endfunction

        // Returns 0 when the transaction is dropped by the block.
        function bit note_input(logic k, char_t c);
            if (k == KIND_END)
            begin
                if (dropping)
                begin
                    dropping = 1'b0;
                    depth    = 0;
                    return 1'b0;
                end
                while (depth > 0)
                begin
                    pop_operator();
                end
                push_expected(CH_NUL, 1'b1, ERR_NONE);
                return 1'b1;
            end
            if (dropping)
            begin
                return 1'b0;
            end
            if (is_operand(c))
            begin
                push_expected(c, 1'b0, ERR_NONE);
                return 1'b1;
            end
            if (c == CH_RPAREN)
            begin
                while (depth > 0 && op_stack[depth - 1] != CH_LPAREN)
                begin
                    pop_operator();
                end
                if (depth == 0)
                begin
                    abort(ERR_UNDERFLOW);
                end
                else
                begin
                    depth--;
                end
                return 1'b1;
            end
            if (c != CH_LPAREN)
            begin
                while (depth > 0 && rank(c) <= rank(op_stack[depth - 1]))
                begin
                    pop_operator();
                end
            end
            if (depth >= DEPTH)
            begin
                abort(ERR_OVERFLOW);
            end
            else
            begin
                op_stack[depth] = c;
                depth++;
            end
            return 1'b1;
        endfunction

        function void check_result(char_t ch, logic l, err_t e);
            postfix_t want;
            if (expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction out_char=%h last=%b error=%0d",
                         $time, ch, l, e);
                return;
            end
            want = expected.pop_front();
            if (ch !== want.ch)
            begin
                errors++;
                $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
            end
            if (l !== want.last)
            begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, l);
            end
            if (e !== want.err)
            begin
                errors++;
                $display("%0t: error expected %0d actual %0d", $time, want.err, e);
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  kind;
    char_t in_char;
    logic  out_valid;
    logic  out_stall = 1'b0;
    char_t out_char;
    logic  last;
    err_t  error;

    postfix_scoreboard sb;
    char_t seq_chars[$];
    int    send_idle_pct = 16;
    int    recv_idle_pct = 60;
    int    live_items    = 0;
    int    cycles        = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .in_char(in_char),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_char(out_char),
        .last(last),
        .error(error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_char, last, error);
        end
    end

    // Called and returns at a falling edge.
    task automatic send_item(logic k, char_t c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = k;
        in_char  = c;
        do
            @(posedge clk);
        while (in_stall);
        void'(sb.note_input(k, c));
        live_items++;
        @(negedge clk);
    endtask

    task automatic flush_seq(bit with_end);
        foreach (seq_chars[i])
        begin
            send_item(KIND_CHAR, seq_chars[i]);
        end
        seq_chars.delete();
        if (with_end)
        begin
            send_item(KIND_END, char_t'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic void add_text(string s);
        foreach (s[i])
        begin
            seq_chars.push_back(char_t'(s[i]));
        end
    endfunction

    function automatic void add_operand();
        case ($urandom_range(2))
            0: seq_chars.push_back(char_t'("0" + $urandom_range(9)));
            1: seq_chars.push_back(char_t'("A" + $urandom_range(25)));
            default: seq_chars.push_back(char_t'("a" + $urandom_range(25)));
        endcase
    endfunction

    function automatic char_t pick_operator();
        char_t ops[5]   = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
        char_t other[6] = '{"%", "=", "!", CH_NUL, 8'h80, 8'hFF};
        if ($urandom_range(99) < 88)
        begin
            return ops[$urandom_range(4)];
        end
        return other[$urandom_range(5)];
    endfunction

    function automatic void add_term(int nest);
        if (nest > 0 && $urandom_range(3) == 0)
        begin
            seq_chars.push_back(CH_LPAREN);
            add_expr(nest - 1);
            seq_chars.push_back(CH_RPAREN);
        end
        else
        begin
            add_operand();
        end
    endfunction

    function automatic void add_expr(int nest);
        add_term(nest);
        repeat ($urandom_range(0, 4))
        begin
            seq_chars.push_back(pick_operator());
            add_term(nest);
        end
    endfunction

    function automatic void add_deep(int opens, int closes);
        repeat (opens) seq_chars.push_back(CH_LPAREN);
        add_operand();
        repeat (closes) seq_chars.push_back(CH_RPAREN);
    endfunction

    task automatic run_phase(int s_pct, int r_pct, int forced_opens);
        int start;
        int sel;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = live_items;
        add_deep(forced_opens, 0);
        flush_seq(1'b1);
        while (live_items - start < ITEMS_PER_PHASE)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                add_expr(3);
                flush_seq(1'b1);
            end
            else if (sel < 68)
            begin
                add_deep($urandom_range(28, 34), $urandom_range(0, 3));
                flush_seq(1'b1);
            end
            else if (sel < 84)
            begin
                add_expr(2);
                seq_chars.insert($urandom_range(seq_chars.size()),
                                 $urandom_range(1) ? CH_RPAREN : CH_LPAREN);
                flush_seq(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    seq_chars.push_back(char_t'($urandom_range(255)));
                flush_seq($urandom_range(1));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = KIND_CHAR;
        in_char  = CH_NUL;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        add_text("a+b*c^d");
        flush_seq(1'b1);
        add_text("(0/Z)^9");
        flush_seq(1'b1);
        // underflow with pending pops, then a dropped char and end
        add_text("A-b)q");
        flush_seq(1'b1);
        seq_chars.push_back(CH_NUL);
        seq_chars.push_back(8'h80);
        seq_chars.push_back(8'hFF);
        seq_chars.push_back(8'h7F);
        add_text("z(%");
        flush_seq(1'b1);
        wait_drained();

        run_phase(16, 60, DEPTH + 1);
        run_phase(60, 16, DEPTH);
        run_phase(0, 0, DEPTH - 1);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
